/* hdl/tmcs_pkg.sv */
// ----------------------------------------------------------------------------
// tmcs_pkg
// shared types and constants of the tile map collision scan unit
// ----------------------------------------------------------------------------
package tmcs_pkg;

  // table geometry
  localparam int NUM_TILES = 256;
  localparam int TILE_AW   = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
  localparam int CNT_W     = $clog2(NUM_TILES + 1);

  // command codes
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_BOX_KIND = 2'd1,
    OP_BOX_WALL = 2'd2,
    OP_CIRCLE   = 2'd3
  } opcode_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [7:0]         kind;
  } tile_entry_t;

endpackage

/* hdl/tile_map_collision_scan_unit.sv */
// ----------------------------------------------------------------------------
// tile_map_collision_scan_unit
// tile table in a synchronous memory, scanned one entry a cycle per query
// ----------------------------------------------------------------------------
// a load writes its table entry and gives no result word
// a query gives its hit word once every entry has been read and the pipeline has drained
// a new query is taken only while busy is low: the scan reads one table entry a cycle,
// then the pipeline drains, then the idle cycle carries the result strobe
// busy is low again in the cycle the result strobe is high; the receiver cannot stall
// reset clears control and clear_type; the table stays undefined until loaded
module tile_map_collision_scan_unit
  import tmcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_tile_index,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [14:0]        in_size_w,
  input  logic [14:0]        in_size_h,
  input  logic [14:0]        in_radius,
  input  logic [7:0]         in_match_kind,
  output logic               out_strobe,
  output logic               out_hit,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state_r;
  logic [CNT_W-1:0] cnt_r;
  logic acc_r;
  logic out_strobe_r;
  logic out_hit_r;
  logic [7:0] clear_type_r;

  // query word held for the whole scan
  opcode_t q_op_r;
  logic signed [15:0] q_px_r;
  logic signed [15:0] q_py_r;
  logic [14:0] q_sw_r;
  logic [14:0] q_sh_r;
  logic [14:0] q_rad_r;
  logic [7:0] q_kind_r;
  logic [29:0] rr_r;

  // pipeline registers
  tile_entry_t rd_entry_r;
  logic s1_vld_r, s1_last_r;
  logic s2_vld_r, s2_last_r, s2_box_r, s2_circ_r;
  logic signed [17:0] dx_r, dy_r;
  logic s3_vld_r, s3_last_r, s3_box_r, s3_circ_r;
  logic [33:0] dx2_r, dy2_r;

  tile_entry_t mem [NUM_TILES];

  logic accept, is_query, ld_ok;
  logic [TILE_AW-1:0] ld_addr;
  tile_entry_t wr_entry;

  assign accept   = start && !busy;
  assign is_query = opcode_t'(in_opcode) != OP_LOAD;
  assign ld_ok    = 32'(in_tile_index) < NUM_TILES;
  assign ld_addr  = TILE_AW'(in_tile_index);

  assign wr_entry.left = in_pos_x;
  assign wr_entry.top  = in_pos_y;
  assign wr_entry.w    = in_size_w;
  assign wr_entry.h    = in_size_h;
  assign wr_entry.kind = in_match_kind;

  // table memory: write on load, registered read during scan
  always_ff @(posedge clk) begin
    if (accept && !is_query && ld_ok) begin
      mem[ld_addr] <= wr_entry;
    end
    rd_entry_r <= mem[cnt_r[TILE_AW-1:0]];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_type_r <= 8'd0;
    end else if (cfg_we) begin
      clear_type_r <= cfg_wdata;
    end
  end

  // capture the query word
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      q_op_r   <= opcode_t'(in_opcode);
      q_px_r   <= in_pos_x;
      q_py_r   <= in_pos_y;
      q_sw_r   <= in_size_w;
      q_sh_r   <= in_size_h;
      q_rad_r  <= in_radius;
      q_kind_r <= in_match_kind;
    end
    rr_r <= 30'(q_rad_r) * 30'(q_rad_r);
  end

  // stage 1: qualify entry, box overlap, clamp distances
  logic signed [17:0] a_x0, a_y0, a_w, a_h, a_x1, a_y1;
  logic signed [17:0] b_x0, b_y0, b_w, b_h, b_x1, b_y1;
  logic signed [17:0] cl_x, cl_y;
  logic qual, box_ov;

  always_comb begin
    a_x0 = {{2{q_px_r[15]}}, q_px_r};
    a_y0 = {{2{q_py_r[15]}}, q_py_r};
    a_w  = {3'b000, q_sw_r};
    a_h  = {3'b000, q_sh_r};
    a_x1 = a_x0 + a_w;
    a_y1 = a_y0 + a_h;
    b_x0 = {{2{rd_entry_r.left[15]}}, rd_entry_r.left};
    b_y0 = {{2{rd_entry_r.top[15]}}, rd_entry_r.top};
    b_w  = {3'b000, rd_entry_r.w};
    b_h  = {3'b000, rd_entry_r.h};
    b_x1 = b_x0 + b_w;
    b_y1 = b_y0 + b_h;

    box_ov = (a_y1 > b_y0) && (a_y0 < b_y1) && (a_x1 > b_x0) && (a_x0 < b_x1);

    // circle centre clamped onto the closed rectangle
    if (a_x0 < b_x0) begin
      cl_x = b_x0;
    end else if (a_x0 > b_x1) begin
      cl_x = b_x1;
    end else begin
      cl_x = a_x0;
    end
    if (a_y0 < b_y0) begin
      cl_y = b_y0;
    end else if (a_y0 > b_y1) begin
      cl_y = b_y1;
    end else begin
      cl_y = a_y0;
    end

    case (q_op_r)
      OP_BOX_KIND: qual = rd_entry_r.kind == q_kind_r;
      OP_BOX_WALL: qual = rd_entry_r.kind > clear_type_r;
      OP_CIRCLE:   qual = rd_entry_r.kind > clear_type_r;
      default:     qual = 1'b0;
    endcase
  end

  // stages 2 and 3: square the distances
  logic signed [35:0] dx_sq, dy_sq;
  assign dx_sq = 36'(dx_r) * 36'(dx_r);
  assign dy_sq = 36'(dy_r) * 36'(dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= state_r == ST_SCAN;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
    s1_last_r <= (state_r == ST_SCAN) && (cnt_r == CNT_W'(NUM_TILES - 1));
    s2_last_r <= s1_vld_r && s1_last_r;
    s2_box_r  <= s1_vld_r && qual && box_ov && (q_op_r != OP_CIRCLE);
    s2_circ_r <= s1_vld_r && qual && (q_op_r == OP_CIRCLE);
    dx_r      <= cl_x - a_x0;
    dy_r      <= cl_y - a_y0;
    s3_last_r <= s2_vld_r && s2_last_r;
    s3_box_r  <= s2_vld_r && s2_box_r;
    s3_circ_r <= s2_vld_r && s2_circ_r;
    dx2_r     <= dx_sq[33:0];
    dy2_r     <= dy_sq[33:0];
  end

  // stage 3 hit of this entry
  logic [34:0] dist_sq;
  logic hit_now;
  assign dist_sq = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign hit_now = s3_vld_r && (s3_box_r || (s3_circ_r && (dist_sq < {5'b00000, rr_r})));

  // sequencer with registered result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      acc_r        <= 1'b0;
      out_strobe_r <= 1'b0;
      out_hit_r    <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept && is_query) begin
            state_r <= ST_SCAN;
            cnt_r   <= '0;
            acc_r   <= 1'b0;
          end
        end
        ST_SCAN: begin
          acc_r <= acc_r | hit_now;
          if (cnt_r == CNT_W'(NUM_TILES - 1)) begin
            state_r <= ST_DRAIN;
          end
          cnt_r <= cnt_r + CNT_W'(1);
        end
        ST_DRAIN: begin
          acc_r <= acc_r | hit_now;
          if (s3_vld_r && s3_last_r) begin
            state_r      <= ST_IDLE;
            out_strobe_r <= 1'b1;
            out_hit_r    <= acc_r | hit_now;
            cnt_r        <= '0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = state_r != ST_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_hit    = out_hit_r;

`ifndef SYNTHESIS
  // result word only once the scan has finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // one result word per query
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on two cycles in a row");

  // a taken query holds the unit busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode != OP_LOAD) |=> busy)
    else $error("query taken but unit not busy");

  // no pipeline word without an active scan
  a_pipe_active: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r || s2_vld_r || s3_vld_r) |-> busy)
    else $error("pipeline word while idle");

  // scan address stays inside the table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (32'(cnt_r) < NUM_TILES))
    else $error("scan counter beyond table");
`endif

endmodule
